/* rtl/core/led_matrix_scan_driver_top_macros.svh */
// Assertion macros for the LED matrix scan driver.
`ifndef LED_MATRIX_SCAN_DRIVER_TOP_MACROS_SVH
`define LED_MATRIX_SCAN_DRIVER_TOP_MACROS_SVH

// Condition must hold at every clock edge out of reset.
`define LMSD_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// Antecedent at one edge implies consequent at the next.
`define LMSD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/lmsd_pkg.sv */
// Types, codes and helpers shared by the LED matrix scan driver.
package lmsd_pkg;

  typedef enum logic [1:0] {
    ACT_TICK  = 2'd0,
    ACT_WRITE = 2'd1,
    ACT_FRAME = 2'd2,
    ACT_STOP  = 2'd3
  } action_e;

  typedef enum logic [2:0] {
    PH_BLANK   = 3'd0,
    PH_ROW     = 3'd1,
    PH_COLOUR  = 3'd2,
    PH_CLK_HI  = 3'd3,
    PH_CLK_LO  = 3'd4,
    PH_LAT_HI  = 3'd5,
    PH_LAT_LO  = 3'd6,
    PH_UNBLANK = 3'd7
  } phase_e;

  localparam logic       REG_CLOCK_WAIT      = 1'b0;
  localparam logic       REG_BRIGHTNESS_WAIT = 1'b1;
  localparam logic [15:0] CLOCK_WAIT_RESET      = 16'd60;
  localparam logic [15:0] BRIGHTNESS_WAIT_RESET = 16'd3000;
  localparam logic [7:0]  DIM_COLOR_CODE        = 8'h25;
  localparam int          MAX_BUF_DEPTH         = 512;

  typedef struct packed {
    logic front_buffer;
    logic new_frame_pending;
    logic frame_shown;
    logic halted;
  } status_t;

  // Step taken by one beat, carried alongside the frame store read.
  typedef struct packed {
    logic       apply;
    phase_e     phase;
    logic [2:0] row;
    logic       blank;
    logic [3:0] pwm;
    logic       top_ok;
    logic       bot_ok;
    status_t    st;
  } step_t;

  // Temporal PWM: channel lit when (frame mod M) < channel value.
  function automatic logic [2:0] pwm_bits(input logic [7:0] c, input logic [3:0] f);
    logic [2:0] res;
    if (c == DIM_COLOR_CODE) begin
      res[2] = {1'b0, f} < {2'b00, c[7:5]};
      res[1] = {1'b0, f} < {2'b00, c[4:2]};
      res[0] = {1'b0, f} < {3'b000, c[1:0]};
    end else begin
      res[2] = f[2:0] < c[7:5];
      res[1] = f[2:0] < c[4:2];
      res[0] = f[1:0] < c[1:0];
    end
    return res;
  endfunction

endpackage

/* rtl/core/led_matrix_scan_driver_top.sv */
// Split-scan RGB LED panel driver with a double-buffered RGB332 frame store.
//
//  channel  | dir | handshake                   | payload
//  s_axis   | in  | s_axis_tvalid/s_axis_tready | tuser action, tdata index+colour
//  m_axis   | out | m_axis_tvalid/m_axis_tready | tdata pin levels and status
//  cfg      | in  | cfg_we_i                    | cfg_index_i, cfg_wdata_i
//
// One beat per cycle unless the output stalls or the clearing pass runs; each
// result passes the frame store read, then the pin update into the output register.
// After reset a clearing pass zeroes all 2 * 2**clog2(min(PANEL_ROWS*PANEL_COLUMNS,
// 512)) frame store entries (1024 by default), one entry per cycle;
// no input beat is taken meanwhile, config writes are.
// A stalled output holds one result plus one in flight, then input stalls.
`include "led_matrix_scan_driver_top_macros.svh"

module led_matrix_scan_driver_top #(
  parameter int PANEL_ROWS    = 16,
  parameter int PANEL_COLUMNS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [8:0] pixel_index, [16:9] pixel_colour, [23:17] zero
  input  logic [23:0] s_axis_tdata,
  // [1:0] action
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [2:0] top_rgb, [5:3] bottom_rgb, [8:6] row_address, [9] shift_clock,
  // [10] latch, [11] output_disable, [12] front_buffer,
  // [13] new_frame_pending, [14] frame_shown, [15] halted
  output logic [15:0] m_axis_tdata,
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [15:0] cfg_wdata_i
);
  import lmsd_pkg::*;

  localparam int HALF_ROWS   = PANEL_ROWS / 2;
  localparam int BUFFER_SIZE = PANEL_ROWS * PANEL_COLUMNS;
  localparam int BUF_DEPTH   = (BUFFER_SIZE < MAX_BUF_DEPTH) ? BUFFER_SIZE : MAX_BUF_DEPTH;
  localparam int AW          = $clog2(BUF_DEPTH);
  localparam int MEM_DEPTH   = 2 * (1 << AW);
  localparam int PIXW        = $clog2(BUFFER_SIZE) + 1;
  localparam int CW          = $clog2(PANEL_COLUMNS + 1);

  // configuration
  logic [15:0] clk_wait_q, bright_wait_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clk_wait_q    <= CLOCK_WAIT_RESET;
      bright_wait_q <= BRIGHTNESS_WAIT_RESET;
    end else if (cfg_we_i) begin
      if (cfg_index_i == REG_CLOCK_WAIT) clk_wait_q <= cfg_wdata_i;
      else                              bright_wait_q <= cfg_wdata_i;
    end
  end

  // clearing pass
  logic          clr_busy_q;
  logic [AW:0]   clr_addr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_addr_q <= '0;
    end else if (clr_busy_q) begin
      clr_addr_q <= clr_addr_q + (AW + 1)'(1);
      if (clr_addr_q == {(AW + 1){1'b1}}) clr_busy_q <= 1'b0;
    end
  end

  // scan state
  logic          disp_q, disp_d;
  logic          swap_q, swap_d;
  logic          shown_q, shown_d;
  logic [3:0]    pwm_q, pwm_d;
  logic [2:0]    row_q, row_d;
  logic [CW-1:0] col_q, col_d;
  phase_e        phase_q, phase_d;
  logic [15:0]   hold_q, hold_d;
  logic          stop_q, stop_d;
  logic          blank_q, blank_d;
  logic          halt_q, halt_d;

  logic          accept;
  action_e       action;
  logic [8:0]    pix_idx;
  logic [7:0]    pix_colour;

  logic          p_valid_q;
  step_t         p_q, step;
  logic          p_adv;

  logic          wr_en;
  logic [AW:0]   wr_addr;
  logic [7:0]    wr_data;
  logic          pix_wr;
  logic [PIXW-1:0] top_idx, bot_idx;
  logic [AW:0]   rd_top_addr, rd_bot_addr;
  logic [7:0]    rd_top_q, rd_bot_q;

  logic [15:0]   wait_sel, hold_eff;
  logic [CW-1:0] col_inc;
  logic [3:0]    row_inc;

  assign action     = action_e'(s_axis_tuser);
  assign pix_idx    = s_axis_tdata[8:0];
  assign pix_colour = s_axis_tdata[16:9];

  assign p_adv         = p_valid_q && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !clr_busy_q && (!p_valid_q || p_adv);
  assign accept        = s_axis_tvalid && s_axis_tready;

  assign top_idx = PIXW'(row_q) * PIXW'(PANEL_COLUMNS) + PIXW'(col_q);
  assign bot_idx = (PIXW'(row_q) + PIXW'(HALF_ROWS)) * PIXW'(PANEL_COLUMNS) + PIXW'(col_q);
  assign rd_top_addr = {disp_q, top_idx[AW-1:0]};
  assign rd_bot_addr = {disp_q, bot_idx[AW-1:0]};

  assign col_inc = col_q + CW'(1);
  assign row_inc = {1'b0, row_q} + 4'd1;

  always_comb begin
    disp_d   = disp_q;
    swap_d   = swap_q;
    shown_d  = shown_q;
    pwm_d    = pwm_q;
    row_d    = row_q;
    col_d    = col_q;
    phase_d  = phase_q;
    hold_d   = hold_q;
    stop_d   = stop_q;
    blank_d  = blank_q;
    halt_d   = halt_q;
    pix_wr   = 1'b0;
    wait_sel = (phase_q == PH_UNBLANK) ? bright_wait_q : clk_wait_q;
    hold_eff = hold_q;

    step        = '0;
    step.phase  = phase_q;
    step.row    = row_q;
    step.blank  = blank_q;
    step.pwm    = pwm_q;
    step.top_ok = top_idx < PIXW'(BUF_DEPTH);
    step.bot_ok = bot_idx < PIXW'(BUF_DEPTH);

    if (accept) begin
      case (action)
        ACT_TICK: begin
          if (!halt_q) begin
            if (hold_q == 16'd0) begin
              step.apply = 1'b1;
              hold_eff   = (wait_sel == 16'd0) ? 16'd1 : wait_sel;
            end
            hold_d = hold_eff - 16'd1;
            if (hold_d == 16'd0) begin
              case (phase_q)
                PH_CLK_LO: begin
                  col_d   = col_inc;
                  phase_d = (col_inc < CW'(PANEL_COLUMNS)) ? PH_COLOUR : PH_LAT_HI;
                end
                PH_UNBLANK: begin
                  col_d   = '0;
                  phase_d = PH_BLANK;
                  row_d   = row_inc[2:0];
                  if (row_inc >= 4'(HALF_ROWS)) begin
                    // frame end
                    row_d = '0;
                    pwm_d = pwm_q + 4'd1;
                    if (blank_q) begin
                      blank_d = 1'b0;
                      halt_d  = 1'b1;
                    end else begin
                      if (swap_q) begin
                        swap_d  = 1'b0;
                        disp_d  = ~disp_q;
                        shown_d = 1'b0;
                      end else begin
                        shown_d = 1'b1;
                      end
                      if (stop_q) blank_d = 1'b1;
                    end
                  end
                end
                default: phase_d = phase_e'(phase_q + 3'd1);
              endcase
            end
          end
        end
        ACT_WRITE: pix_wr = {1'b0, pix_idx} < 10'(BUF_DEPTH);
        ACT_FRAME: swap_d = 1'b1;
        default:   stop_d = 1'b1;
      endcase
    end

    step.st.front_buffer      = disp_d;
    step.st.new_frame_pending = swap_d;
    step.st.frame_shown       = shown_d;
    step.st.halted            = halt_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      disp_q  <= 1'b0;
      swap_q  <= 1'b0;
      shown_q <= 1'b1;
      pwm_q   <= '0;
      row_q   <= '0;
      col_q   <= '0;
      phase_q <= PH_BLANK;
      hold_q  <= '0;
      stop_q  <= 1'b0;
      blank_q <= 1'b0;
      halt_q  <= 1'b0;
    end else begin
      disp_q  <= disp_d;
      swap_q  <= swap_d;
      shown_q <= shown_d;
      pwm_q   <= pwm_d;
      row_q   <= row_d;
      col_q   <= col_d;
      phase_q <= phase_d;
      hold_q  <= hold_d;
      stop_q  <= stop_d;
      blank_q <= blank_d;
      halt_q  <= halt_d;
    end
  end

  // frame store: back buffer written, front buffer read two pixels at once
  logic [7:0] frame_mem [MEM_DEPTH];

  assign wr_en   = clr_busy_q || pix_wr;
  assign wr_addr = clr_busy_q ? clr_addr_q : {~disp_q, pix_idx[AW-1:0]};
  assign wr_data = clr_busy_q ? 8'h00 : pix_colour;

  always_ff @(posedge clk_i) begin
    if (wr_en) frame_mem[wr_addr] <= wr_data;
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      rd_top_q <= frame_mem[rd_top_addr];
      rd_bot_q <= frame_mem[rd_bot_addr];
    end
  end

  // step stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_valid_q <= 1'b0;
    end else if (accept) begin
      p_valid_q <= 1'b1;
    end else if (p_adv) begin
      p_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) p_q <= step;
  end

  // pin levels double as the output register
  logic       m_valid_q;
  logic [2:0] top_q, top_d, bot_q, bot_d, rowa_q, rowa_d;
  logic       sclk_q, sclk_d, lat_q, lat_d, oe_q, oe_d;
  status_t    st_q;

  always_comb begin
    top_d  = top_q;
    bot_d  = bot_q;
    rowa_d = rowa_q;
    sclk_d = sclk_q;
    lat_d  = lat_q;
    oe_d   = oe_q;
    if (p_q.apply) begin
      case (p_q.phase)
        PH_BLANK:  oe_d   = 1'b1;
        PH_ROW:    rowa_d = p_q.row;
        PH_COLOUR: begin
          top_d = (!p_q.blank && p_q.top_ok) ? pwm_bits(rd_top_q, p_q.pwm) : 3'd0;
          bot_d = (!p_q.blank && p_q.bot_ok) ? pwm_bits(rd_bot_q, p_q.pwm) : 3'd0;
        end
        PH_CLK_HI: sclk_d = 1'b1;
        PH_CLK_LO: sclk_d = 1'b0;
        PH_LAT_HI: lat_d  = 1'b1;
        PH_LAT_LO: lat_d  = 1'b0;
        default:   oe_d   = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
      top_q     <= '0;
      bot_q     <= '0;
      rowa_q    <= '0;
      sclk_q    <= 1'b0;
      lat_q     <= 1'b0;
      oe_q      <= 1'b0;
    end else if (p_adv) begin
      m_valid_q <= 1'b1;
      top_q     <= top_d;
      bot_q     <= bot_d;
      rowa_q    <= rowa_d;
      sclk_q    <= sclk_d;
      lat_q     <= lat_d;
      oe_q      <= oe_d;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (p_adv) st_q <= p_q.st;
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {st_q.halted, st_q.frame_shown, st_q.new_frame_pending,
                          st_q.front_buffer, oe_q, lat_q, sclk_q, rowa_q, bot_q, top_q};

  `LMSD_ASSERT(a_no_accept_clearing, !(clr_busy_q && s_axis_tready), "beat taken during clear")
  `LMSD_ASSERT_NEXT(a_halt_sticky, halt_q, halt_q, "halt flag dropped")
  `LMSD_ASSERT(a_col_range, col_q <= CW'(PANEL_COLUMNS), "column count out of range")
  `LMSD_ASSERT_NEXT(a_rd_hold, p_valid_q && !p_adv, $stable(rd_top_q) && $stable(rd_bot_q),
                    "frame store read data lost under stall")
  `LMSD_ASSERT_NEXT(a_swap_only_pending, !swap_q, $stable(disp_q), "buffer swap without request")

endmodule

/* verif/tb_top.sv */
// Self-checking testbench for the LED matrix scan driver: pin and status beats vs. a local model.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import lmsd_pkg::*;

  localparam int ROWS         = 16;
  localparam int COLS         = 32;
  localparam int HALF         = ROWS / 2;
  localparam int BUF_WORDS    = ROWS * COLS;
  localparam int CYCLE_LIMIT  = 200_000;
  localparam int DRAIN_CYCLES = 6;

  // Same bit order as m_axis_tdata.
  typedef struct packed {
    logic       halted;
    logic       frame_shown;
    logic       new_frame_pending;
    logic       front_buffer;
    logic       output_disable;
    logic       latch;
    logic       shift_clock;
    logic [2:0] row_address;
    logic [2:0] bottom_rgb;
    logic [2:0] top_rgb;
  } scan_pins_t;

  typedef enum logic [1:0] {RX_OPEN, RX_CHOPPY, RX_SPARSE} rx_mode_e;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata;
  logic [1:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [15:0] m_axis_tdata;
  logic        cfg_we_i;
  logic        cfg_index_i;
  logic [15:0] cfg_wdata_i;

  led_matrix_scan_driver_top #(
    .PANEL_ROWS   (ROWS),
    .PANEL_COLUMNS(COLS)
  ) u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_wdata_i  (cfg_wdata_i)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Panel model state
  logic [7:0]  fb_mem [0:2*BUF_WORDS-1];
  logic        show_buf;
  logic        swap_pend;
  logic        shown_q;
  logic        stop_pend;
  logic        dark_frame;
  logic        halted_q;
  logic [3:0]  pwm_frame;
  int unsigned row_pair;
  int unsigned col_idx;
  int unsigned hold_left;
  phase_e      scan_phase;
  scan_pins_t  pins_q;
  logic [15:0] clk_wait;
  logic [15:0] lit_wait;
  int          frames_done;

  scan_pins_t  pins_due[$];
  int          mismatches;
  int          sent_beats;
  int          burst_left;
  int          long_hold_req;

  function automatic logic [2:0] lit_channels(input logic [7:0] c, input logic [3:0] f);
    int unsigned mod_rg;
    int unsigned mod_b;
    logic [2:0]  lit;
    mod_rg = (c == DIM_COLOR_CODE) ? 16 : 8;
    mod_b  = (c == DIM_COLOR_CODE) ? 16 : 4;
    lit[2] = (f % mod_rg) < c[7:5];
    lit[1] = (f % mod_rg) < c[4:2];
    lit[0] = (f % mod_b) < c[1:0];
    return lit;
  endfunction

  task automatic close_frame();
    pwm_frame = pwm_frame + 4'd1;
    frames_done++;
    if (dark_frame) begin
      dark_frame = 1'b0;
      halted_q   = 1'b1;
    end else begin
      if (swap_pend) begin
        swap_pend = 1'b0;
        show_buf  = ~show_buf;
        shown_q   = 1'b0;
      end else begin
        shown_q = 1'b1;
      end
      if (stop_pend) dark_frame = 1'b1;
    end
  endtask

  task automatic apply_phase();
    int unsigned base;
    base = show_buf ? BUF_WORDS : 0;
    case (scan_phase)
      PH_BLANK:  pins_q.output_disable = 1'b1;
      PH_ROW:    pins_q.row_address = row_pair[2:0];
      PH_COLOUR: begin
        if (dark_frame) begin
          pins_q.top_rgb    = 3'd0;
          pins_q.bottom_rgb = 3'd0;
        end else begin
          pins_q.top_rgb    = lit_channels(fb_mem[base + row_pair * COLS + col_idx], pwm_frame);
          pins_q.bottom_rgb = lit_channels(fb_mem[base + (row_pair + HALF) * COLS + col_idx],
                                           pwm_frame);
        end
      end
      PH_CLK_HI: pins_q.shift_clock = 1'b1;
      PH_CLK_LO: pins_q.shift_clock = 1'b0;
      PH_LAT_HI: pins_q.latch = 1'b1;
      PH_LAT_LO: pins_q.latch = 1'b0;
      default:   pins_q.output_disable = 1'b0;
    endcase
  endtask

  task automatic next_phase();
    case (scan_phase)
      PH_CLK_LO: begin
        col_idx++;
        scan_phase = (col_idx < COLS) ? PH_COLOUR : PH_LAT_HI;
      end
      PH_UNBLANK: begin
        col_idx    = 0;
        scan_phase = PH_BLANK;
        row_pair++;
        if (row_pair >= HALF) begin
          row_pair = 0;
          close_frame();
        end
      end
      default: scan_phase = phase_e'(scan_phase + 3'd1);
    endcase
  endtask

  task automatic scan_after_beat(input action_e act, input logic [8:0] idx,
                                 input logic [7:0] colour);
    int unsigned hold_len;
    case (act)
      ACT_TICK: begin
        if (!halted_q) begin
          if (hold_left == 0) begin
            hold_len = (scan_phase == PH_UNBLANK) ? 32'(lit_wait) : 32'(clk_wait);
            apply_phase();
            hold_left = (hold_len == 0) ? 1 : hold_len;  // zero wait acts as one tick
          end
          hold_left--;
          if (hold_left == 0) next_phase();
        end
      end
      ACT_WRITE: fb_mem[(show_buf ? 0 : BUF_WORDS) + idx] = colour;
      ACT_FRAME: swap_pend = 1'b1;
      default:   stop_pend = 1'b1;
    endcase
    pins_q.front_buffer      = show_buf;
    pins_q.new_frame_pending = swap_pend;
    pins_q.frame_shown       = shown_q;
    pins_q.halted            = halted_q;
    pins_due.push_back(pins_q);
  endtask

  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      mismatches++;
      $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
    end
  endtask

  task automatic compare_pins(input scan_pins_t want, input scan_pins_t got);
    check_field("top_rgb", 32'(want.top_rgb), 32'(got.top_rgb));
    check_field("bottom_rgb", 32'(want.bottom_rgb), 32'(got.bottom_rgb));
    check_field("row_address", 32'(want.row_address), 32'(got.row_address));
    check_field("shift_clock", 32'(want.shift_clock), 32'(got.shift_clock));
    check_field("latch", 32'(want.latch), 32'(got.latch));
    check_field("output_disable", 32'(want.output_disable), 32'(got.output_disable));
    check_field("front_buffer", 32'(want.front_buffer), 32'(got.front_buffer));
    check_field("new_frame_pending", 32'(want.new_frame_pending),
                32'(got.new_frame_pending));
    check_field("frame_shown", 32'(want.frame_shown), 32'(got.frame_shown));
    check_field("halted", 32'(want.halted), 32'(got.halted));
  endtask

  // Input beats feed the model, output beats are checked against it.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready)
        scan_after_beat(action_e'(s_axis_tuser), s_axis_tdata[8:0], s_axis_tdata[16:9]);
      if (m_axis_tvalid && m_axis_tready) begin
        if (pins_due.size() == 0) begin
          mismatches++;
          $display("%0t: pin beat expected none actual %h", $time, m_axis_tdata);
        end else begin
          compare_pins(pins_due.pop_front(), scan_pins_t'(m_axis_tdata));
        end
      end
    end
  end

  // Output side: stall pattern of its own, plus a long hold on request.
  initial begin
    rx_mode_e rx_mode;
    int       mode_left;
    int       hold_cycles;
    m_axis_tready = 1'b0;
    rx_mode       = RX_OPEN;
    mode_left     = 0;
    hold_cycles   = 0;
    forever begin
      @(negedge clk_i);
      if (long_hold_req > 0) begin
        hold_cycles   = long_hold_req;
        long_hold_req = 0;
      end
      if (hold_cycles > 0) begin
        hold_cycles--;
        m_axis_tready = 1'b0;
      end else begin
        if (mode_left == 0) begin
          rx_mode   = rx_mode_e'($urandom_range(0, 2));
          mode_left = $urandom_range(32, 512);
        end
        mode_left--;
        case (rx_mode)
          RX_OPEN:   m_axis_tready = 1'b1;
          RX_CHOPPY: m_axis_tready = ($urandom_range(0, 3) != 0);
          default:   m_axis_tready = ($urandom_range(0, 2) == 0);
        endcase
      end
    end
  end

  initial begin
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("TEST FAILED");
    $finish;
  end

  // Called at a falling edge; returns at the falling edge after the beat is taken.
  task automatic send_beat(input action_e act, input logic [8:0] idx, input logic [7:0] colour);
    int gap;
    if (burst_left == 0) begin
      s_axis_tvalid = 1'b0;
      gap = $urandom_range(0, 3);
      repeat (gap) @(negedge clk_i);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 400) : $urandom_range(1, 24);
    end
    burst_left--;
    s_axis_tvalid = 1'b1;
    s_axis_tuser  = act;
    s_axis_tdata  = {7'd0, colour, idx};
    do @(posedge clk_i); while (!s_axis_tready);
    sent_beats++;
    @(negedge clk_i);
  endtask

  task automatic tick_beats(input int n);
    repeat (n) send_beat(ACT_TICK, 9'($urandom_range(0, 511)), 8'($urandom_range(0, 255)));
  endtask

  function automatic logic [7:0] pick_colour();
    case ($urandom_range(0, 5))
      0:       return DIM_COLOR_CODE;
      1:       return 8'hFF;
      2:       return 8'h00;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic write_random_pixels(input int n);
    repeat (n) send_beat(ACT_WRITE, 9'($urandom_range(0, 511)), pick_colour());
  endtask

  task automatic drain();
    s_axis_tvalid = 1'b0;
    burst_left    = 0;
    while (pins_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_reg(input logic idx, input logic [15:0] val);
    drain();
    cfg_we_i    = 1'b1;
    cfg_index_i = idx;
    cfg_wdata_i = val;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    if (idx == REG_CLOCK_WAIT) clk_wait = val;
    else lit_wait = val;
  endtask

  task automatic test_directed();
    write_reg(REG_CLOCK_WAIT, 16'd1);
    write_reg(REG_BRIGHTNESS_WAIT, 16'd1);
    send_beat(ACT_WRITE, 9'd0, 8'hFF);
    send_beat(ACT_WRITE, 9'd511, 8'h00);
    send_beat(ACT_WRITE, 9'h0AA, 8'h55);
    send_beat(ACT_WRITE, 9'h155, 8'hAA);
    send_beat(ACT_WRITE, 9'd32, DIM_COLOR_CODE);
    send_beat(ACT_WRITE, 9'd288, 8'hE0);
    send_beat(ACT_WRITE, 9'd256, 8'h03);
    // second frame-ready while one is pending
    send_beat(ACT_FRAME, 9'd0, 8'h00);
    send_beat(ACT_FRAME, 9'h1FF, 8'hFF);
    tick_beats(12);
  endtask

  task automatic test_zero_wait();
    write_reg(REG_CLOCK_WAIT, 16'd0);
    write_reg(REG_BRIGHTNESS_WAIT, 16'd0);
    tick_beats(250);
  endtask

  // More back buffer content, swap request, then run to the frame end where the swap lands.
  task automatic test_frame_scan();
    int start;
    write_reg(REG_CLOCK_WAIT, 16'd1);
    write_reg(REG_BRIGHTNESS_WAIT, 16'($urandom_range(1, 2)));
    send_beat(ACT_WRITE, 9'd1, DIM_COLOR_CODE);
    send_beat(ACT_WRITE, 9'd257, DIM_COLOR_CODE);
    write_random_pixels(96);
    send_beat(ACT_FRAME, 9'd0, 8'd0);
    start = frames_done;
    while (frames_done == start) tick_beats(1);
  endtask

  // Long hold on an ordinary step, then on the lit step.
  task automatic test_wait_extremes();
    write_reg(REG_CLOCK_WAIT, 16'd1);
    write_reg(REG_BRIGHTNESS_WAIT, 16'd1);
    while (hold_left != 0 || scan_phase == PH_UNBLANK) tick_beats(1);
    write_reg(REG_CLOCK_WAIT, 16'd40);
    do tick_beats(1); while (hold_left != 0);
    write_reg(REG_CLOCK_WAIT, 16'd1);
    while (scan_phase != PH_UNBLANK) tick_beats(1);
    write_reg(REG_BRIGHTNESS_WAIT, 16'd60);
    do tick_beats(1); while (hold_left != 0);
    write_reg(REG_BRIGHTNESS_WAIT, 16'd1);
  endtask

  task automatic test_random();
    int seg_start;
    for (int seg = 0; seg < 4; seg++) begin
      write_reg(REG_CLOCK_WAIT, 16'($urandom_range(0, 1)));
      write_reg(REG_BRIGHTNESS_WAIT, 16'($urandom_range(0, 3)));
      // output held off while input keeps coming: block must back up
      if (seg == 1 || seg == 3) long_hold_req = $urandom_range(200, 400);
      seg_start = sent_beats;
      while (sent_beats - seg_start < 100) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3: tick_beats($urandom_range(1, 30));
          4, 5, 6: begin
            write_random_pixels($urandom_range(1, 8));
            if ($urandom_range(0, 1))
              send_beat(ACT_FRAME, 9'($urandom_range(0, 511)), 8'd0);
          end
          7:       send_beat(ACT_FRAME, 9'($urandom_range(0, 511)),
                             8'($urandom_range(0, 255)));
          default: tick_beats($urandom_range(30, 60));
        endcase
      end
    end
  endtask

  // Stop finishes the frame with its swap, draws one dark frame, then halts for good.
  task automatic test_stop_halt();
    int n;
    write_reg(REG_CLOCK_WAIT, 16'd1);
    write_reg(REG_BRIGHTNESS_WAIT, 16'd1);
    write_random_pixels(16);
    send_beat(ACT_FRAME, 9'd0, 8'd0);
    tick_beats($urandom_range(50, 150));
    send_beat(ACT_STOP, 9'd0, 8'd0);
    send_beat(ACT_STOP, 9'h1FF, 8'hFF);
    n = 0;
    while (!halted_q) begin
      tick_beats(1);
      n++;
      if (n == 300) begin
        write_random_pixels(4);
        send_beat(ACT_FRAME, 9'd0, 8'd0);
        send_beat(ACT_STOP, 9'd0, 8'd0);
      end
    end
    tick_beats(40);
    write_random_pixels(4);
    send_beat(ACT_FRAME, 9'd0, 8'd0);
    send_beat(ACT_STOP, 9'd0, 8'd0);
    tick_beats(20);
  endtask

  initial begin
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = ACT_TICK;
    cfg_we_i      = 1'b0;
    cfg_index_i   = REG_CLOCK_WAIT;
    cfg_wdata_i   = '0;
    rst_ni        = 1'b0;
    foreach (fb_mem[i]) fb_mem[i] = 8'd0;
    show_buf      = 1'b0;
    swap_pend     = 1'b0;
    shown_q       = 1'b1;
    stop_pend     = 1'b0;
    dark_frame    = 1'b0;
    halted_q      = 1'b0;
    pwm_frame     = 4'd0;
    row_pair      = 0;
    col_idx       = 0;
    hold_left     = 0;
    scan_phase    = PH_BLANK;
    pins_q        = '0;
    clk_wait      = CLOCK_WAIT_RESET;
    lit_wait      = BRIGHTNESS_WAIT_RESET;
    frames_done   = 0;
    mismatches    = 0;
    sent_beats    = 0;
    burst_left    = 0;
    long_hold_req = 0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed();
    test_zero_wait();
    test_wait_extremes();
    test_frame_scan();
    test_random();
    test_stop_halt();
    drain();

    if (mismatches == 0 && pins_due.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
